// ===== sv/hrbp_pkg.sv =====
package hrbp_pkg;

  typedef enum logic [1:0] {
    StIncomplete = 2'd0,
    StCompleted  = 2'd1,
    StError      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RoleSyntax  = 3'd0,
    RoleMethod  = 3'd1,
    RoleUri     = 3'd2,
    RoleHdrName = 3'd3,
    RoleHdrVal  = 3'd4,
    RoleBody    = 3'd5
  } role_e;

  typedef enum logic [2:0] {
    MmStart = 3'd0,
    MmP     = 3'd1,
    MmPo    = 3'd2,
    MmPos   = 3'd3,
    MmPost  = 3'd4,
    MmPu    = 3'd5,
    MmPut   = 3'd6,
    MmNone  = 3'd7
  } method_e;

  typedef enum logic [1:0] {
    KindOther = 2'd0,
    KindClen  = 2'd1,
    KindTenc  = 2'd2,
    KindConn  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ConnNone  = 2'd0,
    ConnOpen  = 2'd1,
    ConnKa    = 2'd2,
    ConnOther = 2'd3
  } conn_e;

  typedef enum logic [1:0] {
    ClenLead = 2'd0,
    ClenDig  = 2'd1,
    ClenStop = 2'd2
  } clen_e;

  typedef struct packed {
    logic [4:0] pos;
    logic [2:0] alive;  // bit 0 content-length, 1 transfer-encoding, 2 connection
  } name_m_t;

  typedef struct packed {
    logic [3:0] pos;
    logic [1:0] alive;  // bit 0 chunked, 1 keep-alive
  } value_m_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } req_t;

  typedef struct packed {
    status_e    parse_status;
    role_e      byte_role;
    logic [7:0] byte_out;
    logic       new_header;
    logic [7:0] major_version;
    logic [7:0] minor_version;
    logic       keep_alive;
    logic       is_chunked;
  } res_t;

  localparam logic [0:13][7:0] NameCl = "content-length";
  localparam logic [0:16][7:0] NameTe = "transfer-encoding";
  localparam logic [0:9][7:0]  NameCo = "connection";
  localparam logic [0:6][7:0]  ValCh  = "chunked";
  localparam logic [0:9][7:0]  ValKa  = "keep-alive";

  localparam name_m_t NameInit  = '{pos: 5'd0, alive: 3'b111};
  localparam value_m_t ValueInit = '{pos: 4'd0, alive: 2'b11};

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_ctl(input logic [7:0] c);
    return c < 8'd32 || c == 8'd127;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    logic [7:0] l;
    l = lower(c);
    return l >= "a" && l <= "z";
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] l;
    l = lower(c);
    return is_digit(c) || (l >= "a" && l <= "f");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] l;
    l = lower(c);
    return is_digit(c) ? c[3:0] : l[3:0] + 4'd9;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    logic sep;
    case (c) inside
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "=", "{", "}",
      " ", 8'h09, "?": sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return !c[7] && !is_ctl(c) && !sep;
  endfunction

  function automatic logic [7:0] ver_acc(input logic [7:0] v, input logic [3:0] d);
    logic [11:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {8'd0, d};
    return (t > 12'd255) ? 8'd255 : t[7:0];
  endfunction

  function automatic method_e method_next(input method_e m, input logic [7:0] c);
    method_e r;
    r = MmNone;
    case (m)
      MmStart: r = (c == "P") ? MmP : MmNone;
      MmP:     r = (c == "O") ? MmPo : ((c == "U") ? MmPu : MmNone);
      MmPo:    r = (c == "S") ? MmPos : MmNone;
      MmPos:   r = (c == "T") ? MmPost : MmNone;
      MmPu:    r = (c == "T") ? MmPut : MmNone;
      default: r = MmNone;
    endcase
    return r;
  endfunction

  function automatic name_m_t name_feed(input name_m_t m, input logic [7:0] c);
    name_m_t    r;
    logic [7:0] l;
    l = lower(c);
    r = m;
    if (!(m.pos < 5'd14 && l == NameCl[m.pos[3:0]])) r.alive[0] = 1'b0;
    if (!(m.pos < 5'd17 && l == NameTe[m.pos])) r.alive[1] = 1'b0;
    if (!(m.pos < 5'd10 && l == NameCo[m.pos[3:0]])) r.alive[2] = 1'b0;
    if (m.pos < 5'd31) r.pos = m.pos + 5'd1;
    return r;
  endfunction

  function automatic value_m_t value_feed(input value_m_t m, input logic [7:0] c);
    value_m_t   r;
    logic [7:0] l;
    l = lower(c);
    r = m;
    if (!(m.pos < 4'd7 && l == ValCh[m.pos[2:0]])) r.alive[0] = 1'b0;
    if (!(m.pos < 4'd10 && l == ValKa[m.pos])) r.alive[1] = 1'b0;
    if (m.pos < 4'd15) r.pos = m.pos + 4'd1;
    return r;
  endfunction

  function automatic kind_e name_kind(input name_m_t m);
    kind_e k;
    k = KindOther;
    if (m.alive[0] && m.pos == 5'd14) k = KindClen;
    else if (m.alive[1] && m.pos == 5'd17) k = KindTenc;
    else if (m.alive[2] && m.pos == 5'd10) k = KindConn;
    return k;
  endfunction

endpackage

// ===== sv/hrbp_stream_if.sv =====
interface hrbp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/http_request_byte_parser_unit.sv =====
// The result beat is registered: it appears in the cycle after its request beat is accepted.
// Throughput: one byte per cycle while results are taken; the parser state and the result
// register both advance on the same edge, so bytes stream back to back.
// The result register decouples the sides: a new beat is taken while a
// result waits, unless that result is stalled.
// Reset (async, active low) puts the parser at method start with no result.
module http_request_byte_parser_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hrbp_stream_if.sink   req_i,
  hrbp_stream_if.source res_o
);
  import hrbp_pkg::*;

  typedef enum logic [34:0] {
    PhMethodStart  = 35'd1 << 0,
    PhMethod       = 35'd1 << 1,
    PhUriStart     = 35'd1 << 2,
    PhUri          = 35'd1 << 3,
    PhH            = 35'd1 << 4,
    PhHt           = 35'd1 << 5,
    PhHtt          = 35'd1 << 6,
    PhHttp         = 35'd1 << 7,
    PhSlash        = 35'd1 << 8,
    PhMajStart     = 35'd1 << 9,
    PhMaj          = 35'd1 << 10,
    PhMinStart     = 35'd1 << 11,
    PhMin          = 35'd1 << 12,
    PhVerLf        = 35'd1 << 13,
    PhHdrStart     = 35'd1 << 14,
    PhHdrLws       = 35'd1 << 15,
    PhHdrName      = 35'd1 << 16,
    PhHdrSp        = 35'd1 << 17,
    PhHdrValue     = 35'd1 << 18,
    PhHdrLf        = 35'd1 << 19,
    PhEndLf        = 35'd1 << 20,
    PhBody         = 35'd1 << 21,
    PhChunkSize    = 35'd1 << 22,
    PhExtName      = 35'd1 << 23,
    PhExtVal       = 35'd1 << 24,
    PhChunkSizeLf  = 35'd1 << 25,
    PhTrailerStart = 35'd1 << 26,
    PhLastLf       = 35'd1 << 27,
    PhTrailerName  = 35'd1 << 28,
    PhTrailerValue = 35'd1 << 29,
    PhChunkData    = 35'd1 << 30,
    PhDataCr       = 35'd1 << 31,
    PhDataLf       = 35'd1 << 32,
    PhDone         = 35'd1 << 33,
    PhError        = 35'd1 << 34
  } phase_e;

  localparam int LB = LENGTH_BITS;

  function automatic logic [LB-1:0] acc_dec(input logic [LB-1:0] v, input logic [3:0] d);
    logic [LB+3:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{LB{1'b0}}, d};
    return (t[LB+3:LB] != 4'd0) ? {LB{1'b1}} : t[LB-1:0];
  endfunction

  function automatic logic [LB-1:0] acc_hex(input logic [LB-1:0] v, input logic [3:0] h);
    return (v[LB-1:LB-4] != 4'd0) ? {LB{1'b1}} : {v[LB-5:0], h};
  endfunction

  phase_e   phase_q, phase_d;
  logic [LB-1:0] body_q, body_d, chunk_q, chunk_d;
  logic     hexstop_q, hexstop_d;
  logic     chunked_q, chunked_d;
  logic [7:0] major_q, major_d, minor_q, minor_d;
  method_e  method_q, method_d;
  name_m_t  name_q, name_d;
  value_m_t value_q, value_d;
  logic     hseen_q, hseen_d;
  conn_e    conn_q, conn_d;
  logic     ka_q, ka_d;
  kind_e    kind_q, kind_d;
  clen_e    clen_q, clen_d;

  res_t res_d, res_q;
  logic res_valid_q;
  logic accept;

  logic [7:0] c;
  logic       err, newh, nfeed, vfeed, pp;
  role_e      role;
  status_e    status;

  assign c           = req_i.payload.data_byte;
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    if (req_i.payload.restart) begin
      phase_d   = PhMethodStart;
      body_d    = '0;
      chunk_d   = '0;
      hexstop_d = 1'b0;
      chunked_d = 1'b0;
      major_d   = 8'd0;
      minor_d   = 8'd0;
      method_d  = MmStart;
      name_d    = NameInit;
      value_d   = ValueInit;
      hseen_d   = 1'b0;
      conn_d    = ConnNone;
      ka_d      = 1'b0;
      kind_d    = KindOther;
      clen_d    = ClenLead;
    end else begin
      phase_d   = phase_q;
      body_d    = body_q;
      chunk_d   = chunk_q;
      hexstop_d = hexstop_q;
      chunked_d = chunked_q;
      major_d   = major_q;
      minor_d   = minor_q;
      method_d  = method_q;
      name_d    = name_q;
      value_d   = value_q;
      hseen_d   = hseen_q;
      conn_d    = conn_q;
      ka_d      = ka_q;
      kind_d    = kind_q;
      clen_d    = clen_q;
    end

    err   = 1'b0;
    newh  = 1'b0;
    nfeed = 1'b0;
    vfeed = 1'b0;
    role  = RoleSyntax;
    pp    = (method_d == MmPost) || (method_d == MmPut);

    unique case (phase_d)
      PhMethodStart: begin
        if (!is_token(c)) err = 1'b1;
        else begin
          method_d = method_next(MmStart, c);
          role     = RoleMethod;
          phase_d  = PhMethod;
        end
      end
      PhMethod: begin
        if (c == " ") phase_d = PhUriStart;
        else if (!is_token(c)) err = 1'b1;
        else begin
          method_d = method_next(method_d, c);
          role     = RoleMethod;
        end
      end
      PhUriStart: begin
        if (is_ctl(c)) err = 1'b1;
        else begin
          role    = RoleUri;
          phase_d = PhUri;
        end
      end
      PhUri: begin
        if (c == " ") phase_d = PhH;
        else if (c == 8'h0D) begin
          // simple request: version 0.9, done
          major_d = 8'd0;
          minor_d = 8'd9;
          phase_d = PhDone;
        end else if (is_ctl(c)) err = 1'b1;
        else role = RoleUri;
      end
      PhH: begin
        if (c == "H") phase_d = PhHt; else err = 1'b1;
      end
      PhHt: begin
        if (c == "T") phase_d = PhHtt; else err = 1'b1;
      end
      PhHtt: begin
        if (c == "T") phase_d = PhHttp; else err = 1'b1;
      end
      PhHttp: begin
        if (c == "P") phase_d = PhSlash; else err = 1'b1;
      end
      PhSlash: begin
        if (c == "/") begin
          major_d = 8'd0;
          minor_d = 8'd0;
          phase_d = PhMajStart;
        end else err = 1'b1;
      end
      PhMajStart: begin
        if (is_digit(c)) begin
          major_d = {4'd0, c[3:0]};
          phase_d = PhMaj;
        end else err = 1'b1;
      end
      PhMaj: begin
        if (c == ".") phase_d = PhMinStart;
        else if (is_digit(c)) major_d = ver_acc(major_d, c[3:0]);
        else err = 1'b1;
      end
      PhMinStart: begin
        if (is_digit(c)) begin
          minor_d = {4'd0, c[3:0]};
          phase_d = PhMin;
        end else err = 1'b1;
      end
      PhMin: begin
        if (c == 8'h0D) phase_d = PhVerLf;
        else if (is_digit(c)) minor_d = ver_acc(minor_d, c[3:0]);
        else err = 1'b1;
      end
      PhVerLf: begin
        if (c == 8'h0A) phase_d = PhHdrStart; else err = 1'b1;
      end
      PhHdrStart: begin
        if (c == 8'h0D) begin
          if (conn_d == ConnOpen)
            conn_d = (value_d.alive[1] && value_d.pos == 4'd10) ? ConnKa : ConnOther;
          phase_d = PhEndLf;
        end else if (hseen_d && (c == " " || c == 8'h09)) phase_d = PhHdrLws;
        else if (!is_token(c)) err = 1'b1;
        else begin
          if (conn_d == ConnOpen)
            conn_d = (value_d.alive[1] && value_d.pos == 4'd10) ? ConnKa : ConnOther;
          hseen_d = 1'b1;
          kind_d  = KindOther;
          name_d  = NameInit;
          nfeed   = 1'b1;
          role    = RoleHdrName;
          newh    = 1'b1;
          phase_d = PhHdrName;
        end
      end
      PhHdrLws: begin
        if (c == 8'h0D) phase_d = PhHdrLf;
        else if (c == " " || c == 8'h09) begin
          // skip folding whitespace
        end else if (is_ctl(c)) err = 1'b1;
        else begin
          vfeed   = 1'b1;
          role    = RoleHdrVal;
          phase_d = PhHdrValue;
        end
      end
      PhHdrName: begin
        if (c == ":") begin
          kind_d = name_kind(name_d);
          if (kind_d == KindConn && conn_d == ConnNone) conn_d = ConnOpen;
          phase_d = PhHdrSp;
        end else if (!is_token(c)) err = 1'b1;
        else begin
          nfeed = 1'b1;
          role  = RoleHdrName;
        end
      end
      PhHdrSp: begin
        if (c == " ") begin
          value_d = ValueInit;
          clen_d  = ClenLead;
          if (kind_d == KindClen && pp) body_d = '0;
          phase_d = PhHdrValue;
        end else err = 1'b1;
      end
      PhHdrValue: begin
        if (c == 8'h0D) begin
          if (kind_d == KindTenc && pp && value_d.alive[0] && value_d.pos == 4'd7)
            chunked_d = 1'b1;
          phase_d = PhHdrLf;
        end else if (is_ctl(c)) err = 1'b1;
        else begin
          vfeed = 1'b1;
          role  = RoleHdrVal;
        end
      end
      PhHdrLf: begin
        if (c == 8'h0A) phase_d = PhHdrStart; else err = 1'b1;
      end
      PhEndLf: begin
        if (conn_d == ConnKa) ka_d = 1'b1;
        else if (conn_d == ConnOther) ka_d = 1'b0;
        else if (major_d > 8'd1 || (major_d == 8'd1 && minor_d == 8'd1)) ka_d = 1'b1;
        if (c != 8'h0A) err = 1'b1;
        else if (chunked_d) phase_d = PhChunkSize;
        else if (body_d == '0) phase_d = PhDone;
        else phase_d = PhBody;
      end
      PhBody: begin
        role   = RoleBody;
        body_d = body_d - {{(LB-1){1'b0}}, 1'b1};
        if (body_d == '0) phase_d = PhDone;
      end
      PhChunkSize: begin
        if (is_alnum(c)) begin
          if (!hexstop_d && is_hex(c)) chunk_d = acc_hex(chunk_d, hex_val(c));
          else hexstop_d = 1'b1;
        end else if (c == ";") phase_d = PhExtName;
        else if (c == 8'h0D) phase_d = PhChunkSizeLf;
        else err = 1'b1;
      end
      PhExtName: begin
        if (is_alnum(c) || c == " ") begin
          // ignore extension name
        end else if (c == "=") phase_d = PhExtVal;
        else if (c == 8'h0D) phase_d = PhChunkSizeLf;
        else err = 1'b1;
      end
      PhExtVal, PhTrailerValue: begin
        if (is_alnum(c) || c == " ") begin
          // ignore value text
        end else if (c == 8'h0D) phase_d = PhChunkSizeLf;
        else err = 1'b1;
      end
      PhChunkSizeLf: begin
        if (c == 8'h0A) begin
          hexstop_d = 1'b0;
          phase_d   = (chunk_d == '0) ? PhTrailerStart : PhChunkData;
        end else err = 1'b1;
      end
      PhTrailerStart: begin
        if (c == 8'h0D) phase_d = PhLastLf;
        else if (is_alpha(c)) phase_d = PhTrailerName;
        else err = 1'b1;
      end
      PhLastLf: begin
        if (c == 8'h0A) phase_d = PhDone; else err = 1'b1;
      end
      PhTrailerName: begin
        if (is_alnum(c)) begin
          // ignore trailer name
        end else if (c == ":") phase_d = PhTrailerValue;
        else err = 1'b1;
      end
      PhChunkData: begin
        role    = RoleBody;
        chunk_d = chunk_d - {{(LB-1){1'b0}}, 1'b1};
        if (chunk_d == '0) phase_d = PhDataCr;
      end
      PhDataCr: begin
        if (c == 8'h0D) phase_d = PhDataLf; else err = 1'b1;
      end
      PhDataLf: begin
        if (c == 8'h0A) phase_d = PhChunkSize; else err = 1'b1;
      end
      PhDone: begin
        // hold until restart
      end
      default: err = 1'b1;
    endcase

    if (nfeed) name_d = name_feed(name_d, c);

    if (vfeed) begin
      value_d = value_feed(value_d, c);
      if (kind_d == KindClen && pp) begin
        if (clen_d == ClenLead && c == " ") begin
          // skip leading space
        end else if (clen_d == ClenLead && c == "+") clen_d = ClenDig;
        else if (clen_d != ClenStop && is_digit(c)) begin
          body_d = acc_dec(body_d, c[3:0]);
          clen_d = ClenDig;
        end else begin
          if (clen_d == ClenLead && c == "-") body_d = '0;
          clen_d = ClenStop;
        end
      end
    end

    if (err) begin
      phase_d = PhError;
      role    = RoleSyntax;
      newh    = 1'b0;
    end

    if (phase_d == PhDone) status = StCompleted;
    else if (phase_d == PhError) status = StError;
    else status = StIncomplete;

    res_d.parse_status  = status;
    res_d.byte_role     = role;
    res_d.byte_out      = c;
    res_d.new_header    = newh;
    res_d.major_version = major_d;
    res_d.minor_version = minor_d;
    res_d.keep_alive    = ka_d;
    res_d.is_chunked    = chunked_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhMethodStart;
      body_q      <= '0;
      chunk_q     <= '0;
      hexstop_q   <= 1'b0;
      chunked_q   <= 1'b0;
      major_q     <= 8'd0;
      minor_q     <= 8'd0;
      method_q    <= MmStart;
      name_q      <= NameInit;
      value_q     <= ValueInit;
      hseen_q     <= 1'b0;
      conn_q      <= ConnNone;
      ka_q        <= 1'b0;
      kind_q      <= KindOther;
      clen_q      <= ClenLead;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        body_q    <= body_d;
        chunk_q   <= chunk_d;
        hexstop_q <= hexstop_d;
        chunked_q <= chunked_d;
        major_q   <= major_d;
        minor_q   <= minor_d;
        method_q  <= method_d;
        name_q    <= name_d;
        value_q   <= value_d;
        hseen_q   <= hseen_d;
        conn_q    <= conn_d;
        ka_q      <= ka_d;
        kind_q    <= kind_d;
        clen_q    <= clen_d;
      end
      // hold the result beat until taken
      if (accept) res_valid_q <= 1'b1;
      else if (res_o.ready) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

endmodule
